@@ rtl/core/edg_pkg.sv @@
package edg_pkg;

	// fixed-point layout
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int MAG_W     = 38;
	localparam int TERM_W    = MAG_W + 1;
	localparam int SUM_W     = MAG_W + 3;
	localparam int PROD_W    = MAG_W + WORD_W;
	localparam int DIFF_W    = 32;
	localparam int SIG_W     = 37;
	localparam int R_W       = 20;
	localparam int Z_W       = 26;
	localparam int DENS_W    = 32;
	localparam int NUM_SH    = 39 - FRAC_BITS;
	localparam int NUM_W     = 62 - NUM_SH;
	localparam int SQUARINGS = 12;

	localparam logic [MAG_W-1:0]  LIM          = {MAG_W{1'b1}};
	localparam logic [22:0]       K_SIGMA      = 23'd7124628;
	localparam logic [30:0]       INV_SQRT_2PI = 31'd1713444047;
	localparam logic [31:0]       Q31_ONE      = 32'h8000_0000;
	localparam logic [31:0]       RECIP3       = 32'hAAAA_AAAB;
	localparam int                RECIP3_SH    = 33;

	// register indexes
	localparam logic [1:0] REG_COEF_0 = 2'd0;
	localparam logic [1:0] REG_COEF_1 = 2'd1;
	localparam logic [1:0] REG_COEF_2 = 2'd2;
	localparam logic [1:0] REG_COEF_3 = 2'd3;

	typedef logic [WORD_W-1:0] coef_t;

	// status that travels with an item down the pipe
	typedef struct packed {
		logic             vld;
		logic             inv;
		logic             tail;
		logic [SIG_W-1:0] sigma;
	} tag_t;

	// magnitude of a two's complement word
	function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] a);
		return a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
	endfunction

	// product >> FRAC_BITS, clamped at LIM
	function automatic logic [MAG_W-1:0] clamp_mag(input logic [PROD_W-1:0] p);
		logic [MAG_W-1:0] r;
		if (|p[PROD_W-1:FRAC_BITS+MAG_W]) begin
			r = LIM;
		end else begin
			r = p[FRAC_BITS+MAG_W-1:FRAC_BITS];
		end
		return r;
	endfunction

	function automatic logic signed [TERM_W-1:0] apply_sign(input logic neg,
			input logic [MAG_W-1:0] m);
		logic [TERM_W-1:0] e;
		e = {1'b0, m};
		return neg ? $signed(-e) : $signed(e);
	endfunction

endpackage

@@ rtl/core/edg_poly.sv @@
module edg_poly (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_vld,
	input  logic [31:0]                  frequency,
	input  logic [31:0]                  energy,
	input  edg_pkg::coef_t               coef [4],
	output edg_pkg::tag_t                tag_o,
	output logic [edg_pkg::DIFF_W-1:0]   diff_o
);
	import edg_pkg::*;

	logic [WORD_W-1:0] mf, mc1, mc2, mc3;
	logic signed [32:0] de;
	logic [32:0]        de_mag;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [WORD_W-1:0]   mf_s1, mf_s2;
	logic                sf_s1, sf_s2, sf_s3, sf_s4;
	logic [DIFF_W-1:0]   d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7, d_s8, d_s9;
	logic [63:0]         pff_s1, pc1_s1;
	logic                n1_s1, n2_s3, n3_s5;
	logic [MAG_W-1:0]    f2_s2, f3m_s4;
	logic signed [TERM_W-1:0] t1_s2, t1_s3, t1_s4, t1_s5, t1_s6;
	logic signed [TERM_W-1:0] t2_s4, t2_s5, t2_s6, t3_s6;
	logic [PROD_W-1:0]   pf3_s3, pc2_s3, pc3_s5;
	logic signed [SUM_W-1:0] sum;
	logic [MAG_W-1:0]    fmag_s7;
	logic                inv_s7, inv_s8, inv_s9;
	logic [MAG_W+22:0]   psig_s8;
	logic [SIG_W-1:0]    sigma_s9;

	assign mf     = mag32(frequency);
	assign mc1    = mag32(coef[REG_COEF_1]);
	assign mc2    = mag32(coef[REG_COEF_2]);
	assign mc3    = mag32(coef[REG_COEF_3]);
	assign de     = $signed({frequency[31], frequency}) - $signed({energy[31], energy});
	assign de_mag = de[32] ? 33'(-de) : 33'(de);

	// polynomial sum of the clamped terms
	assign sum = SUM_W'($signed(coef[REG_COEF_0])) + SUM_W'(t1_s6) + SUM_W'(t2_s6)
		+ SUM_W'(t3_s6);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
			vld_s7 <= 1'b0; vld_s8 <= 1'b0; vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
			vld_s4 <= vld_s3; vld_s5 <= vld_s4; vld_s6 <= vld_s5;
			vld_s7 <= vld_s6; vld_s8 <= vld_s7; vld_s9 <= vld_s8;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: f*f and c1*f
			mf_s1  <= mf;
			sf_s1  <= frequency[31];
			d_s1   <= de_mag[DIFF_W-1:0];
			pff_s1 <= mf * mf;
			pc1_s1 <= mc1 * mf;
			n1_s1  <= coef[REG_COEF_1][31] ^ frequency[31];
			// s2: scale and clamp
			mf_s2  <= mf_s1;
			sf_s2  <= sf_s1;
			d_s2   <= d_s1;
			f2_s2  <= clamp_mag(PROD_W'(pff_s1));
			t1_s2  <= apply_sign(n1_s1, clamp_mag(PROD_W'(pc1_s1)));
			// s3: f^3 and c2*f^2
			sf_s3  <= sf_s2;
			d_s3   <= d_s2;
			t1_s3  <= t1_s2;
			pf3_s3 <= f2_s2 * mf_s2;
			pc2_s3 <= mc2 * f2_s2;
			n2_s3  <= coef[REG_COEF_2][31];
			// s4
			sf_s4  <= sf_s3;
			d_s4   <= d_s3;
			t1_s4  <= t1_s3;
			f3m_s4 <= clamp_mag(pf3_s3);
			t2_s4  <= apply_sign(n2_s3, clamp_mag(pc2_s3));
			// s5: c3*f^3
			d_s5   <= d_s4;
			t1_s5  <= t1_s4;
			t2_s5  <= t2_s4;
			pc3_s5 <= mc3 * f3m_s4;
			n3_s5  <= coef[REG_COEF_3][31] ^ (sf_s4 && (f3m_s4 != '0));
			// s6
			d_s6   <= d_s5;
			t1_s6  <= t1_s5;
			t2_s6  <= t2_s5;
			t3_s6  <= apply_sign(n3_s5, clamp_mag(pc3_s5));
			// s7: width, non-positive marks invalid
			d_s7   <= d_s6;
			inv_s7 <= sum[SUM_W-1] || (sum == '0);
			fmag_s7 <= (sum > $signed({3'b000, LIM})) ? LIM : sum[MAG_W-1:0];
			// s8: width to sigma
			d_s8   <= d_s7;
			inv_s8 <= inv_s7;
			psig_s8 <= fmag_s7 * K_SIGMA;
			// s9
			d_s9   <= d_s8;
			sigma_s9 <= psig_s8[MAG_W+22:24];
			inv_s9 <= inv_s8 || (psig_s8[MAG_W+22:24] == '0);
		end
	end

	assign tag_o.vld   = vld_s9;
	assign tag_o.inv   = inv_s9;
	assign tag_o.tail  = 1'b0;
	assign tag_o.sigma = sigma_s9;
	assign diff_o      = d_s9;

endmodule

@@ rtl/core/edg_ratio.sv @@
module edg_ratio (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  edg_pkg::tag_t              tag_i,
	input  logic [edg_pkg::DIFF_W-1:0] diff_i,
	output edg_pkg::tag_t              tag_o,
	output logic [edg_pkg::R_W-1:0]    r_o
);
	import edg_pkg::*;

	localparam int REM_W = DIFF_W + 16;
	localparam int CMP_W = SIG_W + R_W;

	// entry 0 is the set-up stage, then one quotient bit per stage
	tag_t             tag_s [R_W+1];
	logic [REM_W-1:0] rem_s [R_W+1];
	logic [R_W-1:0]   q_s   [R_W+1];
	tag_t             tag_in;

	// far-tail test: |f-e| at or beyond sixteen sigma
	always_comb begin
		tag_in      = tag_i;
		tag_in.tail = {9'b0, diff_i} >= {tag_i.sigma, 4'b0};
	end

	// set-up: status and dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (adv) begin
			tag_s[0] <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= {diff_i, 16'b0};
			q_s[0]   <= '0;
		end
	end

	// restoring division, MSB first
	for (genvar k = 0; k < R_W; k++) begin : g_div
		logic [CMP_W-1:0] cand;
		logic             ge;

		assign cand = {tag_s[k].sigma, {R_W{1'b0}}} >> (k + 1);
		assign ge   = {{(CMP_W-REM_W){1'b0}}, rem_s[k]} >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (adv) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? (rem_s[k] - cand[REM_W-1:0]) : rem_s[k];
				q_s[k+1]   <= q_s[k] | (ge ? (R_W'(1) << (R_W - 1 - k)) : '0);
			end
		end
	end

	assign tag_o = tag_s[R_W];
	assign r_o   = q_s[R_W];

endmodule

@@ rtl/core/edg_exp.sv @@
module edg_exp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  edg_pkg::tag_t           tag_i,
	input  logic [edg_pkg::R_W-1:0] r_i,
	output edg_pkg::tag_t           tag_o,
	output logic [31:0]             ev_o
);
	import edg_pkg::*;

	localparam int NS = 9;

	tag_t              tag_s [NS+SQUARINGS+1];
	logic [2*R_W-1:0]  rr_s1;
	logic [Z_W-1:0]    z_s2, z_s3, z_s4, z_s5, z_s6, z_s7, z_s8;
	logic [31:0]       t_s2, t_s5, t_s7, t_s9;
	logic [Z_W+31:0]   p_s3, p_s6, p_s8;
	logic [Z_W+32:0]   m3_s4;
	logic [31:0]       sq_s [SQUARINGS+1];

	// status follows the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) tag_s[i] <= '0;
		end else if (adv) begin
			tag_s[1] <= tag_i;
			for (int i = 2; i <= NS; i++) tag_s[i] <= tag_s[i-1];
		end
	end

	// u^2/2 and Horner steps of the series for exp(-z)
	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s1 <= r_i * r_i;
			z_s2  <= {rr_s1[2*R_W-1:17], 3'b000};
			t_s2  <= Q31_ONE - {8'b0, rr_s1[2*R_W-1:17], 1'b0};
			z_s3  <= z_s2;
			p_s3  <= z_s2 * t_s2;
			z_s4  <= z_s3;
			m3_s4 <= p_s3[Z_W+31:31] * RECIP3;
			z_s5  <= z_s4;
			t_s5  <= Q31_ONE - 32'(m3_s4[Z_W+32:RECIP3_SH]);
			z_s6  <= z_s5;
			p_s6  <= z_s5 * t_s5;
			z_s7  <= z_s6;
			t_s7  <= Q31_ONE - 32'(p_s6[Z_W+31:32]);
			z_s8  <= z_s7;
			p_s8  <= z_s7 * t_s7;
			t_s9  <= Q31_ONE - 32'(p_s8[Z_W+31:31]);
		end
	end

	assign sq_s[0] = t_s9;

	// repeated squaring, one per stage
	for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
		logic [63:0] prod;

		assign prod = sq_s[k] * sq_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[NS+k+1] <= '0;
			end else if (adv) begin
				tag_s[NS+k+1] <= tag_s[NS+k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= prod[62:31];
			end
		end
	end

	assign tag_s[0] = tag_i;
	assign tag_o    = tag_s[NS+SQUARINGS];
	assign ev_o     = sq_s[SQUARINGS];

endmodule

@@ rtl/core/edg_norm.sv @@
module edg_norm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  edg_pkg::tag_t              tag_i,
	input  logic [31:0]                ev_i,
	output logic                       vld_o,
	output logic [edg_pkg::DENS_W-1:0] density_o,
	output logic                       inv_o,
	output logic                       sat_o
);
	import edg_pkg::*;

	localparam int CMP_W = SIG_W + DENS_W;

	tag_t              tag_s1;
	logic [62:0]       pn_s1;
	tag_t              tag_s [DENS_W+1];
	logic              sat_s [DENS_W+1];
	logic [NUM_W-1:0]  rem_s [DENS_W+1];
	logic [DENS_W-1:0] q_s   [DENS_W+1];
	logic [NUM_W-1:0]  num;
	tag_t              tag_f;

	assign num = pn_s1[NUM_SH+NUM_W-1:NUM_SH];

	// scale by 1/sqrt(2 pi), then overflow test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			tag_s[0] <= '0;
		end else if (adv) begin
			tag_s1   <= tag_i;
			tag_s[0] <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_s1    <= ev_i * INV_SQRT_2PI;
			rem_s[0] <= num;
			q_s[0]   <= '0;
			sat_s[0] <= {{(CMP_W-NUM_W){1'b0}}, num} >= {tag_s1.sigma, {DENS_W{1'b0}}};
		end
	end

	// restoring division by sigma, MSB first
	for (genvar k = 0; k < DENS_W; k++) begin : g_div
		logic [CMP_W-1:0] cand;
		logic             ge;

		assign cand = {tag_s[k].sigma, {DENS_W{1'b0}}} >> (k + 1);
		assign ge   = {{(CMP_W-NUM_W){1'b0}}, rem_s[k]} >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (adv) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sat_s[k+1] <= sat_s[k];
				rem_s[k+1] <= ge ? (rem_s[k] - cand[NUM_W-1:0]) : rem_s[k];
				q_s[k+1]   <= q_s[k] | (ge ? (DENS_W'(1) << (DENS_W - 1 - k)) : '0);
			end
		end
	end

	assign tag_f = tag_s[DENS_W];

	// result register: invalid width first, then far tail, then clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= tag_f.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_o <= tag_f.inv;
			sat_o <= !tag_f.inv && !tag_f.tail && sat_s[DENS_W];
			if (tag_f.inv || tag_f.tail) begin
				density_o <= '0;
			end else if (sat_s[DENS_W]) begin
				density_o <= '1;
			end else begin
				density_o <= q_s[DENS_W];
			end
		end
	end

endmodule

@@ rtl/core/energy_dependent_gaussian_eval_unit.sv @@
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata[63:0]     frequency, energy (Q16.16)
// m_axis    out  tvalid tready tdata[31:0]     density (Q8.24)
//                tuser[1:0]                    width_invalid, saturated
// cfg       in   cfg_we cfg_index cfg_data     fwhm_coef_0..3
//
// One item per cycle when the result register is free; the two bit-per-stage dividers
// give 20 quotient bits for |f-e|/sigma and 32 for the final normalisation.
// The whole pipe advances together when the result register is empty or taken.
// Reset clears all valid bits and the coefficients; no clearing pass.
module energy_dependent_gaussian_eval_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] frequency, [63:32] energy
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] density
	output logic [1:0]  m_axis_tuser,   // [0] width_invalid, [1] saturated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import edg_pkg::*;

	coef_t             coef_q [4];
	logic              adv;
	tag_t              tag_p, tag_r, tag_e;
	logic [DIFF_W-1:0] diff_p;
	logic [R_W-1:0]    r_r;
	logic [31:0]       ev_e;
	logic              inv, sat;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// pipe moves when the result register can take an item
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	edg_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (s_axis_tvalid),
		.frequency (s_axis_tdata[31:0]),
		.energy    (s_axis_tdata[63:32]),
		.coef      (coef_q),
		.tag_o     (tag_p),
		.diff_o    (diff_p)
	);

	edg_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_i  (tag_p),
		.diff_i (diff_p),
		.tag_o  (tag_r),
		.r_o    (r_r)
	);

	edg_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_i  (tag_r),
		.r_i    (r_r),
		.tag_o  (tag_e),
		.ev_o   (ev_e)
	);

	edg_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tag_i     (tag_e),
		.ev_i      (ev_e),
		.vld_o     (m_axis_tvalid),
		.density_o (m_axis_tdata),
		.inv_o     (inv),
		.sat_o     (sat)
	);

	assign m_axis_tuser = {sat, inv};

endmodule

@@ rtl/core/edg_checker.sv @@
module edg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// input side takes items exactly when the result register frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output");

	// invalid width gives zero density and no clamp
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
		else $error("invalid width with non-zero density");

	// clamp gives full scale
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '1)
		else $error("saturated flag without full-scale density");

endmodule

bind energy_dependent_gaussian_eval_unit edg_checker u_edg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
